// ===== rtl/core/clp_pkg.sv =====
// ----------------------------------------------------------------------------
// clp_pkg: shared types, codes and helpers for the CPU list parser
// Holds the status codes, character codes and the mask and count functions.
// ----------------------------------------------------------------------------
package clp_pkg;

  // Size of the CPU set; the mask port is this wide
  localparam int CpuSetSize = 64;
  localparam int GroupCount = CpuSetSize / 8;

  typedef logic [CpuSetSize-1:0]         mask_t;
  typedef logic [1:0]                    status_t;
  typedef logic [6:0]                    num_t;
  typedef logic [3:0]                    grp_cnt_t;
  typedef grp_cnt_t [GroupCount-1:0]     grp_cnts_t;

  // Status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_MALFORMED = 2'd1;
  localparam status_t ST_RANGE     = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Inclusive run of ones from lo up to hi
  function automatic mask_t span_mask(logic [5:0] lo, logic [5:0] hi);
    mask_t all;
    all = '1;
    return (all >> (6'd63 - hi)) & (all << lo);
  endfunction

  // Ones in one byte of the mask
  function automatic grp_cnt_t count_byte(logic [7:0] b);
    grp_cnt_t n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + grp_cnt_t'(b[i]);
    end
    return n;
  endfunction

  // Add up the per-byte counts
  function automatic num_t sum_groups(grp_cnts_t g);
    num_t n;
    n = '0;
    for (int i = 0; i < GroupCount; i++) begin
      n = n + num_t'(g[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/cpu_list_parser.sv =====
// ----------------------------------------------------------------------------
// cpu_list_parser: CPU list string to CPU mask
// Parses a list such as 0-3,8,10-11 one byte per word, zero byte terminated.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle, also across string ends, while the result
//   register has room. A terminator passes the input register, the parse step into
//   the result register, then the count stage into the output register.
// Reset: rst clears all valids and the parse state; the block then waits
//   for the first byte of a new string.
module cpu_list_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              text_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output clp_pkg::status_t        status,
  output clp_pkg::mask_t          cpu_mask,
  output logic [6:0]              cpu_total
);

  // Parse phase codes
  localparam logic [2:0] PH_START  = 3'd0;  // string not yet begun
  localparam logic [2:0] PH_FIRST  = 3'd1;  // reading a single number or range start
  localparam logic [2:0] PH_DASH   = 3'd2;  // seen '-', range end needed
  localparam logic [2:0] PH_SECOND = 3'd3;  // reading range end
  localparam logic [2:0] PH_COMMA  = 3'd4;  // seen ',', next item or end

  // Input register
  logic        byte_vld;
  logic [7:0]  byte_q;

  // Parse state
  logic [2:0]           phase, phase_next;
  clp_pkg::num_t        accum, accum_next;
  clp_pkg::num_t        range_start, range_start_next;
  clp_pkg::mask_t       chosen_mask, chosen_mask_next;
  clp_pkg::status_t     error_status, error_status_next;

  // Result register: status, mask and per-byte counts
  logic                 res_vld;
  clp_pkg::status_t     res_status;
  clp_pkg::mask_t       res_mask;
  clp_pkg::grp_cnts_t   res_cnts;

  // Handshake chain
  logic out_free, res_free, s0_adv;

  // Parse datapath
  logic                 is_end, is_digit, in_num;
  logic [3:0]           digit;
  logic [9:0]           acc_x10;
  clp_pkg::num_t        acc_sat;
  logic                 fin_bad_rev, fin_bad_rng, fin_ok;
  clp_pkg::status_t     fin_code;
  clp_pkg::num_t        fin_lo;
  clp_pkg::mask_t       fin_set;
  clp_pkg::status_t     end_status;
  clp_pkg::mask_t       end_mask;
  clp_pkg::mask_t       end_mask_out;
  clp_pkg::grp_cnts_t   end_cnts;

  // A terminator needs room in the result register; other bytes never stall
  assign out_free = !out_valid || out_ready;
  assign res_free = !res_vld || out_free;
  assign is_end   = byte_q == clp_pkg::CH_NUL;
  assign s0_adv   = byte_vld && (!is_end || res_free);
  assign in_ready = !byte_vld || s0_adv;

  assign is_digit = byte_q >= clp_pkg::CH_ZERO && byte_q <= clp_pkg::CH_NINE;
  assign digit    = 4'(byte_q - clp_pkg::CH_ZERO);
  assign in_num   = phase == PH_FIRST || phase == PH_SECOND;

  // Decimal step, saturating at the set size so a long number stays out of range
  assign acc_x10 = ({3'b0, accum} << 3) + ({3'b0, accum} << 1) + {6'b0, digit};
  assign acc_sat = (acc_x10 > 10'(clp_pkg::CpuSetSize)) ?
                   clp_pkg::num_t'(clp_pkg::CpuSetSize) : acc_x10[6:0];

  // Closing a number: a reversed range is checked before the set size
  assign fin_bad_rev = phase == PH_SECOND && accum < range_start;
  assign fin_bad_rng = accum >= clp_pkg::num_t'(clp_pkg::CpuSetSize);
  assign fin_ok      = !fin_bad_rev && !fin_bad_rng;
  assign fin_code    = fin_bad_rev ? clp_pkg::ST_MALFORMED : clp_pkg::ST_RANGE;
  assign fin_lo      = (phase == PH_FIRST) ? accum : range_start;
  assign fin_set     = chosen_mask | clp_pkg::span_mask(fin_lo[5:0], accum[5:0]);

  // Final status and mask at the terminator
  always_comb begin
    end_status = error_status;
    end_mask   = chosen_mask;
    if (error_status == clp_pkg::ST_OK) begin
      if (in_num) begin
        if (!fin_ok) begin
          end_status = fin_code;
        end else begin
          end_mask = fin_set;
        end
      end else if (phase != PH_COMMA) begin
        end_status = clp_pkg::ST_MALFORMED;
      end
      // nothing chosen counts as malformed
      if (end_status == clp_pkg::ST_OK && end_mask == '0) begin
        end_status = clp_pkg::ST_MALFORMED;
      end
    end
    end_mask_out = (end_status == clp_pkg::ST_OK) ? end_mask : '0;
    for (int g = 0; g < clp_pkg::GroupCount; g++) begin
      end_cnts[g] = clp_pkg::count_byte(end_mask_out[8*g +: 8]);
    end
  end

  // Parse state update for one byte
  always_comb begin
    phase_next        = phase;
    accum_next        = accum;
    range_start_next  = range_start;
    chosen_mask_next  = chosen_mask;
    error_status_next = error_status;
    if (is_end) begin
      // clear for the next string
      phase_next        = PH_START;
      accum_next        = '0;
      range_start_next  = '0;
      chosen_mask_next  = '0;
      error_status_next = clp_pkg::ST_OK;
    end else if (error_status == clp_pkg::ST_OK) begin
      if (is_digit) begin
        if (in_num) begin
          accum_next = acc_sat;
        end else if (phase == PH_START || phase == PH_COMMA) begin
          accum_next = {3'b0, digit};
          phase_next = PH_FIRST;
        end else if (phase == PH_DASH) begin
          accum_next = {3'b0, digit};
          phase_next = PH_SECOND;
        end else begin
          error_status_next = clp_pkg::ST_MALFORMED;
        end
      end else if (!in_num) begin
        // non-digit byte with no number in front
        error_status_next = clp_pkg::ST_MALFORMED;
      end else if (!fin_ok) begin
        error_status_next = fin_code;
      end else begin
        chosen_mask_next = fin_set;
        accum_next       = '0;
        if (byte_q == clp_pkg::CH_COMMA) begin
          phase_next = PH_COMMA;
        end else if (byte_q == clp_pkg::CH_DASH && phase == PH_FIRST) begin
          range_start_next = accum;
          phase_next       = PH_DASH;
        end else begin
          error_status_next = clp_pkg::ST_MALFORMED;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld     <= 1'b0;
      phase        <= PH_START;
      accum        <= '0;
      range_start  <= '0;
      chosen_mask  <= '0;
      error_status <= clp_pkg::ST_OK;
      res_vld      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_ready) begin
        byte_vld <= in_valid;
      end
      if (s0_adv) begin
        phase        <= phase_next;
        accum        <= accum_next;
        range_start  <= range_start_next;
        chosen_mask  <= chosen_mask_next;
        error_status <= error_status_next;
      end
      if (res_free) begin
        res_vld <= s0_adv && is_end;
      end
      if (out_free) begin
        out_valid <= res_vld;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= text_byte;
    end
    if (s0_adv && is_end) begin
      res_status <= end_status;
      res_mask   <= end_mask_out;
      res_cnts   <= end_cnts;
    end
    if (res_vld && out_free) begin
      status    <= res_status;
      cpu_mask  <= res_mask;
      cpu_total <= clp_pkg::sum_groups(res_cnts);
    end
  end

`ifndef SYNTHESIS
  a_err_clears_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != clp_pkg::ST_OK |-> cpu_mask == '0 && cpu_total == '0)
    else $error("error result carries a mask or count");

  a_ok_has_cpus: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == clp_pkg::ST_OK |-> cpu_mask != '0)
    else $error("ok result with empty mask");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cpu_total == 7'($countones(cpu_mask)))
    else $error("count does not match mask");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    error_status == clp_pkg::ST_OK || error_status == clp_pkg::ST_MALFORMED ||
    error_status == clp_pkg::ST_RANGE)
    else $error("bad error status code");

  a_res_held: assert property (@(posedge clk) disable iff (rst)
    res_vld && !out_free |=> res_vld && $stable(res_mask))
    else $error("pending result dropped");
`endif

endmodule

// ===== tb/cpu_list_parser_tb.sv =====
// ----------------------------------------------------------------------------
// cpu_list_parser_tb: self-checking bench for the CPU list parser
// Feeds zero-terminated CPU list strings one byte word at a time, predicts
// status, mask and count for every terminator, and checks each result word
// in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module cpu_list_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clp_pkg::*;

  localparam int ByteBudget      = 1100;   // byte words in the whole run
  localparam int HoldCycles      = 300;    // long receiver hold-off
  localparam int DrainCycles     = 12;     // settle time after the last result
  localparam int CycleLimit      = 400000;
  localparam int ShownMismatches = 10;

  // Parse phases of the predictor
  typedef enum logic [2:0] {
    LP_IDLE,        // string not begun
    LP_NUM,         // reading a single number or a range start
    LP_DASH,        // saw '-', need the range end
    LP_RANGE_END,   // reading the range end
    LP_COMMA        // saw ',', need the next item or the end
  } list_phase_e;

  typedef struct packed {
    status_t    st;
    mask_t      mask;
    logic [6:0] cnt;
  } list_result_t;

  // One directed string; a typed row carries its expected result
  typedef struct {
    string        text;
    bit           typed;
    list_result_t want;
  } list_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] text_byte;
  logic       out_valid;
  logic       out_ready;
  status_t    status;
  mask_t      cpu_mask;
  logic [6:0] cpu_total;

  cpu_list_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_byte (text_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cpu_mask  (cpu_mask),
    .cpu_total (cpu_total)
  );

  // Predictor state: the list parse as the block should see it
  list_phase_e lp_phase;
  int          acc_num;
  int          first_num;
  mask_t       sel_mask;
  status_t     list_err;

  list_result_t pending_results[$];
  list_row_t    dir_rows[$];

  int  cycle_count   = 0;
  int  bad_results   = 0;
  int  checked       = 0;
  int  strings_sent  = 0;
  int  sent_words    = 0;
  int  ok_seen       = 0;
  int  malformed_seen = 0;
  int  range_seen    = 0;
  int  holds_done    = 0;
  bit  hold_req      = 1'b0;
  bit  sender_idle   = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pending_results.size());
      $display("cpu_list_parser_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void clear_list();
    lp_phase  = LP_IDLE;
    acc_num   = 0;
    first_num = 0;
    sel_mask  = '0;
    list_err  = ST_OK;
  endfunction

  // Keep only the first error of a string
  function automatic void mark_error(status_t code);
    if (list_err == ST_OK) list_err = code;
  endfunction

  // End the number being read; set its bits when it is good
  function automatic bit close_number();
    if (lp_phase == LP_NUM) begin
      if (acc_num >= CpuSetSize) begin
        mark_error(ST_RANGE);
        return 1'b0;
      end
      sel_mask[acc_num] = 1'b1;
      return 1'b1;
    end
    if (acc_num < first_num) begin
      mark_error(ST_MALFORMED);
      return 1'b0;
    end
    if (acc_num >= CpuSetSize) begin
      mark_error(ST_RANGE);
      return 1'b0;
    end
    for (int i = first_num; i <= acc_num; i++) sel_mask[i] = 1'b1;
    return 1'b1;
  endfunction

  // Advance the parse by one byte; return 1 when the byte closes a string
  function automatic bit parse_char(input logic [7:0] c, output list_result_t res);
    bit was_num;
    int digit;
    res = '0;
    if (c == CH_NUL) begin
      if (list_err == ST_OK) begin
        if (lp_phase == LP_NUM || lp_phase == LP_RANGE_END) void'(close_number());
        else if (lp_phase != LP_COMMA) mark_error(ST_MALFORMED);
        if (list_err == ST_OK && sel_mask == '0) mark_error(ST_MALFORMED);
      end
      res.st = list_err;
      if (list_err == ST_OK) begin
        res.mask = sel_mask;
        res.cnt  = 7'($countones(sel_mask));
      end
      clear_list();
      return 1'b1;
    end
    if (list_err != ST_OK) return 1'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = int'(c) - int'(CH_ZERO);
      case (lp_phase)
        LP_NUM, LP_RANGE_END: begin
          acc_num = acc_num * 10 + digit;
          if (acc_num > CpuSetSize) acc_num = CpuSetSize;
        end
        LP_IDLE, LP_COMMA: begin
          acc_num  = digit;
          lp_phase = LP_NUM;
        end
        default: begin
          acc_num  = digit;
          lp_phase = LP_RANGE_END;
        end
      endcase
      return 1'b0;
    end
    if (lp_phase != LP_NUM && lp_phase != LP_RANGE_END) begin
      mark_error(ST_MALFORMED);
      return 1'b0;
    end
    was_num = (lp_phase == LP_NUM);
    if (!close_number()) return 1'b0;
    if (c == CH_COMMA) begin
      lp_phase = LP_COMMA;
    end else if (c == CH_DASH && was_num) begin
      first_num = acc_num;
      lp_phase  = LP_DASH;
    end else begin
      mark_error(ST_MALFORMED);
    end
    acc_num = 0;
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one byte word, hold it until taken, then advance the predictor
  task automatic send_word(input logic [7:0] b, output bit closes, output list_result_t res);
    int gap;
    gap = sender_idle ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
    closes = parse_char(b, res);
  endtask

  // Send a whole string plus its terminator and queue the result it owes
  task automatic send_text(input string s, input bit typed, input list_result_t want);
    bit           closes;
    list_result_t res;
    sender_idle = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < s.len(); i++) send_word(s[i], closes, res);
    send_word(CH_NUL, closes, res);
    pending_results.push_back(typed ? want : res);
    strings_sent++;
  endtask

  task automatic add_row(input string text, input bit typed = 1'b0,
                         input status_t st = ST_OK, input mask_t m = '0,
                         input logic [6:0] n = '0);
    list_row_t row;
    row.text      = text;
    row.typed     = typed;
    row.want.st   = st;
    row.want.mask = m;
    row.want.cnt  = n;
    dir_rows.push_back(row);
  endtask

  // Decimal text, now and then with a leading zero
  function automatic string num_text(int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) s = {"0", s};
    return s;
  endfunction

  // Favor the ends of the set; a few numbers land beyond it
  function automatic int pick_cpu();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return CpuSetSize - 1;
    if (r < 20) return $urandom_range(CpuSetSize, 20000);
    return $urandom_range(0, CpuSetSize - 1);
  endfunction

  // A list of singles and ranges with random content; some ranges are reversed or end beyond the set
  function automatic string make_list();
    string s;
    int    items;
    int    lo;
    int    hi;
    int    r;
    s     = "";
    items = $urandom_range(1, 5);
    for (int k = 0; k < items; k++) begin
      lo = pick_cpu();
      if (k > 0) s = {s, ","};
      if ($urandom_range(0, 1) == 0) begin
        s = {s, num_text(lo)};
      end else begin
        r = $urandom_range(0, 99);
        if (lo >= CpuSetSize) hi = lo;
        else if (r < 6 && lo > 0) hi = $urandom_range(0, lo - 1);        // reversed
        else if (r < 10) hi = $urandom_range(CpuSetSize, 300);           // end too big
        else hi = $urandom_range(lo, CpuSetSize - 1);
        s = {s, num_text(lo), "-", num_text(hi)};
      end
    end
    if ($urandom_range(0, 4) == 0) s = {s, ","};
    return s;
  endfunction

  // Replace one byte of a list, or hang a stray separator on it
  function automatic string break_list(string s);
    logic [7:0] ch;
    int         pos;
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) == 0) return {s, "-"};
      return {s, ",,"};
    end
    case ($urandom_range(0, 3))
      0:       ch = CH_COMMA;
      1:       ch = CH_DASH;
      default: ch = 8'($urandom_range(1, 255));
    endcase
    pos = $urandom_range(0, s.len() - 1);
    s.putc(pos, ch);
    return s;
  endfunction

  // Random nonzero bytes, possibly none at all
  function automatic string make_noise();
    string s;
    int    len;
    s   = "";
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      s = {s, " "};
      s.putc(s.len() - 1, 8'($urandom_range(1, 255)));
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    bit calm;
    stall_left = 0;
    calm       = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // hold off so the block backs up and stalls its input
        hold_req = 1'b0;
        holds_done++;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      if ($urandom_range(0, 63) == 0) calm = !calm;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every result word against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= ShownMismatches)
          $display("%0t: unexpected result: status %0d mask %h count %0d",
                   $realtime, status, cpu_mask, cpu_total);
      end else begin
        want = pending_results.pop_front();
        checked++;
        case (want.st)
          ST_OK:        ok_seen++;
          ST_MALFORMED: malformed_seen++;
          default:      range_seen++;
        endcase
        if (status !== want.st || cpu_mask !== want.mask || cpu_total !== want.cnt) begin
          bad_results++;
          if (bad_results <= ShownMismatches)
            $display({"%0t: result %0d mismatch: expected status %0d mask %h count %0d,",
                      " got status %0d mask %h count %0d"},
                     $realtime, checked, want.st, want.mask, want.cnt,
                     status, cpu_mask, cpu_total);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    string s;
    int    r;
    bit    mid_hold;
    in_valid  = 1'b0;
    text_byte = '0;
    rst       = 1'b1;
    mid_hold  = 1'b0;
    clear_list();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings: extremes, every separator, each error kind
    add_row("", 1'b1, ST_MALFORMED);                                // empty string
    add_row("0", 1'b1, ST_OK, 64'h1, 7'd1);
    add_row("63", 1'b1, ST_OK, 64'h8000_0000_0000_0000, 7'd1);
    add_row("0-63", 1'b1, ST_OK, '1, 7'd64);                        // full set
    add_row("64", 1'b1, ST_RANGE);
    add_row("0-3,8,10-11");
    add_row("5-3", 1'b1, ST_MALFORMED);                             // reversed range
    add_row("1,", 1'b1, ST_OK, 64'h2, 7'd1);                        // trailing comma
    add_row(",", 1'b1, ST_MALFORMED);
    add_row("1,,2", 1'b1, ST_MALFORMED);                            // missing number
    add_row("-3", 1'b1, ST_MALFORMED);
    add_row("1-", 1'b1, ST_MALFORMED);
    add_row("1-2-3", 1'b1, ST_MALFORMED);
    add_row("3 4", 1'b1, ST_MALFORMED);                             // whitespace
    add_row("+1", 1'b1, ST_MALFORMED);                              // sign
    add_row("\377", 1'b1, ST_MALFORMED);                            // top byte value
    add_row("1:", 1'b1, ST_MALFORMED);                              // just past '9'
    add_row("64x", 1'b1, ST_RANGE);                                 // range before bad char
    add_row("70-2", 1'b1, ST_RANGE);
    add_row("7-99999", 1'b1, ST_RANGE);                             // saturating end
    add_row("00000000000000065", 1'b1, ST_RANGE);
    add_row("007,010");
    add_row("x,1", 1'b1, ST_MALFORMED);                             // rest ignored
    add_row("9-9", 1'b1, ST_OK, 64'h200, 7'd1);
    add_row("62-63,0-1,5");
    foreach (dir_rows[i]) send_text(dir_rows[i].text, dir_rows[i].typed, dir_rows[i].want);

    // Random strings: mostly good lists, some broken, some noise
    hold_req = 1'b1;
    while (sent_words < ByteBudget) begin
      if (!mid_hold && sent_words >= ByteBudget / 2) begin
        mid_hold = 1'b1;
        hold_req = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 75) s = make_list();
      else if (r < 90) s = break_list(make_list());
      else s = make_noise();
      send_text(s, 1'b0, '0);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d strings (%0d directed, %0d byte words), %0d results checked:",
             strings_sent, dir_rows.size(), sent_words, checked);
    $display("  %0d ok, %0d malformed, %0d out of range, %0d long receiver hold-offs",
             ok_seen, malformed_seen, range_seen, holds_done);
    $display("%0d mismatches, %0d cycles", bad_results, cycle_count);
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("cpu_list_parser_tb: PASS");
    end else begin
      $display("cpu_list_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
